>>> hw/rtl/sds_pkg.sv
// Shared types and constants of the stereo doubler saturator.
`timescale 1ns / 1ps
`default_nettype none

package sds_pkg;

	// Default sizes of the delay line and the lookup tables.
	localparam int DELAY_DEPTH_DEF     = 2048;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int TANH_TABLE_BITS_DEF = 10;

	// Configuration bus.
	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	// Register reset values.
	localparam logic [12:0] MIX_RST  = 13'd0;
	localparam logic [13:0] VOL_RST  = 14'd4096;
	localparam logic [10:0] BASE_RST = 11'd576;
	localparam logic [31:0] LFO_RST  = 32'd71583;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_MIX  = 2'd0,
		REG_VOL  = 2'd1,
		REG_BASE = 2'd2,
		REG_LFO  = 2'd3
	} sds_reg_t;

	// Register file contents handed to the datapath.
	typedef struct packed {
		logic [12:0] mix_amount;
		logic [13:0] volume_gain;
		logic [10:0] base_delay;
		logic [31:0] lfo_step;
	} sds_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/sds_if.sv
// Stream interfaces for input and output stereo words.
`timescale 1ns / 1ps
`default_nettype none

interface sds_in_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] left_in;
	logic signed [23:0] right_in;
	modport source (output valid, left_in, right_in, input ready);
	modport sink (input valid, left_in, right_in, output ready);
endinterface

interface sds_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] left_out;
	logic signed [23:0] right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sds_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/sds_regs.sv
// APB configuration registers of the stereo doubler saturator.
`timescale 1ns / 1ps
`default_nettype none

module sds_regs
	import sds_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [CFG_AW-1:0]   paddr,
	input  wire [CFG_DW-1:0]   pwdata,
	output logic [CFG_DW-1:0]  prdata,
	output logic               pready,
	output sds_cfg_t           cfg
);

	sds_cfg_t cfg_q;
	sds_reg_t idx;

	assign idx    = sds_reg_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mix_amount  <= MIX_RST;
			cfg_q.volume_gain <= VOL_RST;
			cfg_q.base_delay  <= BASE_RST;
			cfg_q.lfo_step    <= LFO_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_MIX:  cfg_q.mix_amount  <= pwdata[12:0];
				REG_VOL:  cfg_q.volume_gain <= pwdata[13:0];
				REG_BASE: cfg_q.base_delay  <= pwdata[10:0];
				REG_LFO:  cfg_q.lfo_step    <= pwdata;
				default:  cfg_q <= cfg_q;
			endcase
		end
	end

	// Read back.
	always_comb begin
		unique case (idx)
			REG_MIX:  prdata = {19'd0, cfg_q.mix_amount};
			REG_VOL:  prdata = {18'd0, cfg_q.volume_gain};
			REG_BASE: prdata = {21'd0, cfg_q.base_delay};
			REG_LFO:  prdata = cfg_q.lfo_step;
			default:  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/sds_core.sv
// Per-frame sequencer and datapath around the delay line memory.
`timescale 1ns / 1ps
`default_nettype none

module sds_core
	import sds_pkg::*;
#(
	parameter int DELAY_DEPTH     = DELAY_DEPTH_DEF,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
	parameter int TANH_TABLE_BITS = TANH_TABLE_BITS_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire sds_cfg_t cfg,
	sds_in_if.sink        din,
	sds_out_if.source     dout
);

	localparam int AW     = $clog2(DELAY_DEPTH);
	localparam int MAW    = $clog2(2 * DELAY_DEPTH);
	localparam int CW     = (AW + 1 > 11) ? AW + 1 : 11;
	localparam int RW     = AW + 3;
	localparam int TB     = TANH_TABLE_BITS;
	localparam int TANH_N = 1 << TB;
	localparam int SB     = SINE_TABLE_BITS;

	localparam longint unsigned Q30    = 64'd1 << 30;
	localparam longint unsigned EXP_M1 = 64'd395007542;

	localparam logic [31:0] SIN_T25    = 32'd172723447;
	localparam logic [31:0] SIN_T75    = 32'd579705780;
	localparam logic [15:0] DECAY_Q16  = 16'd65208;
	localparam logic [13:0] BOOST_HI   = 14'd8602;
	localparam logic [13:0] BOOST_LO   = 14'd4710;
	localparam logic [13:0] DRIVE_BASE = 14'd5530;
	localparam logic [12:0] MIX_MAX    = 13'd4096;
	localparam logic [13:0] VOL_MAX    = 14'd8192;

	typedef logic [23:0] rom_t [TANH_N+1];

	// Long division by shift and subtract, used while the table is built.
	function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
		longint unsigned q, rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem  = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Tanh table, tanh(i*8/2^TB) in Q1.23, built at elaboration.
	function automatic rom_t build_tanh();
		rom_t            r;
		longint unsigned zq, k, f, term, e, j, n;
		longint          sum;
		for (int i = 0; i <= TANH_N; i++) begin
			zq   = longint'(i) << (34 - TB);
			k    = zq >> 30;
			f    = zq & (Q30 - 64'd1);
			term = Q30;
			sum  = longint'(Q30);
			for (n = 1; n <= 24; n++) begin
				term = udiv64((term * f) >> 30, n);
				if (n[0]) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			e = longint'(sum);
			for (j = 0; j < k; j++) begin
				e = (e * EXP_M1 + (Q30 >> 1)) >> 30;
			end
			r[i] = 24'(udiv64(((Q30 - e) << 23) + ((Q30 + e) >> 1), Q30 + e));
		end
		return r;
	endfunction

	localparam rom_t TANH_ROM = build_tanh();

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_BMOD = 14'b00000000000010,
		ST_WR   = 14'b00000000000100,
		ST_RD   = 14'b00000000001000,
		ST_RDW  = 14'b00000000010000,
		ST_ARG  = 14'b00000000100000,
		ST_TAB  = 14'b00000001000000,
		ST_INT  = 14'b00000010000000,
		ST_DRY  = 14'b00000100000000,
		ST_ACC  = 14'b00001000000000,
		ST_VOL  = 14'b00010000000000,
		ST_SAT  = 14'b00100000000000,
		ST_DONE = 14'b01000000000000,
		ST_SPR  = 14'b10000000000000
	} state_t;

	state_t state_q;

	// Control state.
	logic          ch_q;
	logic          active_q;
	logic          full_q;
	logic          dval_q;
	logic          out_valid_q;
	logic [AW-1:0] widx_q;
	logic [31:0]   phase_q;
	logic [22:0]   env_q [2];

	// Payload registers.
	logic signed [23:0] x_q [2];
	logic signed [23:0] y_q [2];
	logic signed [23:0] lo_q, ro_q;
	logic [12:0]        mix_q;
	logic [13:0]        vol_q;
	logic signed [2:0]  m_q;
	logic [CW-1:0]      bm_q;
	logic [AW-1:0]      rd_q;
	logic [13:0]        boost_q;
	logic signed [38:0] sum_q;
	logic signed [53:0] arg_q;
	logic [23:0]        t0_q;
	logic signed [24:0] diff_q;
	logic [15:0]        frac_q;
	logic               neg_q;
	logic signed [24:0] wet_q;
	logic signed [37:0] dry_q;
	logic signed [38:0] acc_q;
	logic signed [53:0] prod_q;

	// Memory port.
	logic           mem_we;
	logic [MAW-1:0] mem_waddr, mem_raddr;
	logic [23:0]    mem_rdata;

	sds_ram #(
		.WIDTH (24),
		.DEPTH (2 * DELAY_DEPTH)
	) u_delay (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (x_q[ch_q]),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	logic           accept;
	logic           out_free;
	logic signed [23:0] xs;

	assign accept   = din.valid && din.ready;
	assign out_free = !out_valid_q || dout.ready;
	assign xs       = x_q[ch_q];

	assign din.ready      = (state_q == ST_IDLE);
	assign dout.valid     = out_valid_q;
	assign dout.left_out  = lo_q;
	assign dout.right_out = ro_q;

	// LFO offset: quantized phase folded into the first quadrant.
	logic [31:0]       lfo_p, lfo_a;
	logic [1:0]        lfo_mag;
	logic signed [2:0] lfo_m;
	always_comb begin
		lfo_p = {phase_q[31:32-SB], {(32 - SB){1'b0}}};
		lfo_a = {1'b0, lfo_p[30:0]};
		if (lfo_a > 32'h4000_0000) begin
			lfo_a = 32'h8000_0000 - lfo_a;
		end
		lfo_mag = (lfo_a >= SIN_T75) ? 2'd2 : ((lfo_a >= SIN_T25) ? 2'd1 : 2'd0);
		lfo_m   = lfo_p[31] ? -$signed({1'b0, lfo_mag}) : $signed({1'b0, lfo_mag});
	end

	// Envelope magnitude, decayed envelope and transient test.
	logic [23:0] xabs;
	logic [22:0] mag, dec;
	logic [38:0] dec_full;
	logic        transient;
	always_comb begin
		xabs      = xs[23] ? 24'(-xs) : 24'(xs);
		mag       = xabs[23] ? 23'h7F_FFFF : xabs[22:0];
		dec_full  = env_q[ch_q] * DECAY_Q16;
		dec       = dec_full[38:16];
		transient = ({2'b00, mag, 2'b00} > (27'(env_q[ch_q]) * 27'd5));
	end

	// Read index with two-sided wrap.
	logic signed [RW-1:0] r0, r1, r2;
	logic signed [2:0]    moff;
	always_comb begin
		moff = ch_q ? -m_q : m_q;
		r0 = $signed({3'b000, widx_q}) - $signed({3'b000, bm_q[AW-1:0]}) - RW'(moff);
		r1 = (r0 < 0) ? r0 + RW'(DELAY_DEPTH) : r0;
		if (r1 < 0) begin
			r2 = r1 + RW'(DELAY_DEPTH);
		end else if (r1 >= RW'(DELAY_DEPTH)) begin
			r2 = r1 - RW'(DELAY_DEPTH);
		end else begin
			r2 = r1;
		end
	end

	// Memory addressing: left line first, right line above it.
	always_comb begin
		mem_we    = (state_q == ST_WR);
		mem_waddr = MAW'(widx_q) + (ch_q ? MAW'(DELAY_DEPTH) : MAW'(0));
		mem_raddr = MAW'(rd_q) + (ch_q ? MAW'(DELAY_DEPTH) : MAW'(0));
	end

	// Tanh lookup operands.
	logic [53:0]   arg_abs;
	logic [53:0]   tidx_full;
	logic [TB-1:0] tidx;
	always_comb begin
		arg_abs   = arg_q[53] ? 54'(-arg_q) : 54'(arg_q);
		tidx_full = arg_abs >> (50 - TB);
		tidx      = arg_abs[50-TB +: TB];
	end

	// Interpolation and output scaling.
	logic signed [41:0] interp;
	logic signed [25:0] wmag;
	logic signed [23:0] dval;
	logic signed [54:0] rnd;
	logic signed [30:0] shifted;
	logic signed [23:0] ysat;
	always_comb begin
		interp  = diff_q * $signed({1'b0, frac_q});
		wmag    = $signed({2'b00, t0_q}) + 26'(interp >>> 16);
		dval    = dval_q ? $signed(mem_rdata) : 24'sd0;
		rnd     = 55'(prod_q) + 55'sd8388608;
		shifted = 31'(rnd >>> 24);
		if (shifted > 31'sd8388607) begin
			ysat = 24'sd8388607;
		end else if (shifted < -31'sd8388608) begin
			ysat = -24'sd8388608;
		end else begin
			ysat = shifted[23:0];
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			active_q    <= 1'b0;
			full_q      <= 1'b0;
			dval_q      <= 1'b0;
			out_valid_q <= 1'b0;
			widx_q      <= '0;
			phase_q     <= '0;
			env_q[0]    <= '0;
			env_q[1]    <= '0;
		end else begin
			// The done step reloads the output register itself.
			if (out_valid_q && dout.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q     <= 1'b0;
						active_q <= (cfg.mix_amount != 13'd0);
						state_q  <= (cfg.mix_amount != 13'd0) ? ST_BMOD : ST_DRY;
					end
				end
				ST_BMOD: begin
					if (bm_q < CW'(DELAY_DEPTH)) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					env_q[ch_q] <= (mag > dec) ? mag : dec;
					state_q     <= ST_RD;
				end
				ST_RD: begin
					dval_q  <= full_q || (rd_q <= widx_q);
					state_q <= ST_RDW;
				end
				ST_RDW:  state_q <= ST_ARG;
				ST_ARG:  state_q <= ST_TAB;
				ST_TAB:  state_q <= ST_INT;
				ST_INT:  state_q <= ST_DRY;
				ST_DRY:  state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_VOL;
				ST_VOL:  state_q <= ST_SAT;
				ST_SAT: begin
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= active_q ? ST_WR : ST_DRY;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (active_q) begin
							phase_q <= phase_q + cfg.lfo_step;
							if (widx_q == AW'(DELAY_DEPTH - 1)) begin
								widx_q <= '0;
								full_q <= 1'b1;
							end else begin
								widx_q <= widx_q + AW'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q[0] <= din.left_in;
				x_q[1] <= din.right_in;
				mix_q  <= (cfg.mix_amount > MIX_MAX) ? MIX_MAX : cfg.mix_amount;
				vol_q  <= (cfg.volume_gain > VOL_MAX) ? VOL_MAX : cfg.volume_gain;
				m_q    <= lfo_m;
				bm_q   <= CW'(cfg.base_delay);
				wet_q  <= '0;
			end
			ST_BMOD: begin
				if (bm_q >= CW'(DELAY_DEPTH)) begin
					bm_q <= bm_q - CW'(DELAY_DEPTH);
				end
			end
			ST_WR: begin
				boost_q <= transient ? BOOST_HI : BOOST_LO;
				rd_q    <= r2[AW-1:0];
			end
			ST_RDW: begin
				sum_q <= 39'(xs * $signed({1'b0, boost_q}))
					+ 39'(dval * $signed({1'b0, BOOST_LO}));
			end
			ST_ARG: begin
				arg_q <= 54'(sum_q * $signed({1'b0, DRIVE_BASE + 14'(mix_q)}));
			end
			ST_TAB: begin
				neg_q <= arg_q[53];
				if (tidx_full >= 54'(TANH_N)) begin
					t0_q   <= TANH_ROM[TANH_N];
					diff_q <= '0;
					frac_q <= '0;
				end else begin
					t0_q   <= TANH_ROM[tidx];
					diff_q <= $signed({1'b0, TANH_ROM[(TB+1)'(tidx) + (TB+1)'(1)]})
						- $signed({1'b0, TANH_ROM[tidx]});
					frac_q <= arg_abs[34-TB +: 16];
				end
			end
			ST_INT: begin
				wet_q <= neg_q ? 25'(-wmag) : 25'(wmag);
			end
			ST_DRY: begin
				dry_q <= 38'(xs * $signed({1'b0, MIX_MAX - mix_q}));
			end
			ST_ACC: begin
				acc_q <= 39'(dry_q) + 39'(wet_q * $signed({1'b0, mix_q}));
			end
			ST_VOL: begin
				prod_q <= 54'(acc_q * $signed({1'b0, vol_q}));
			end
			ST_SAT: begin
				y_q[ch_q] <= ysat;
				wet_q     <= '0;
			end
			ST_DONE: begin
				if (out_free) begin
					lo_q <= y_q[0];
					ro_q <= y_q[1];
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/stereo_doubler_saturator_unit.sv
// Top level of the stereo doubler saturator.
`timescale 1ns / 1ps
`default_nettype none

// Processes one stereo word at a time. With mix_amount nonzero the
// sequencer runs ten steps per channel around the delay line memory (write,
// read, registered read data, then the saturator and mix multiplies) and
// first reduces base_delay by repeated subtraction. With mix_amount zero
// only the dry, accumulate, volume and saturate steps run per channel. The
// sequencer returns to idle before the next word can be taken, and a stalled
// output register holds the sequencer in its last step. The output register
// holds a result while the next word is taken. The delay line reads as zero
// wherever it has not yet been written since reset, so no clearing pass is
// needed.
module stereo_doubler_saturator_unit
	import sds_pkg::*;
#(
	parameter int DELAY_DEPTH     = DELAY_DEPTH_DEF,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
	parameter int TANH_TABLE_BITS = TANH_TABLE_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	sds_in_if.sink            din,
	sds_out_if.source         dout,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [CFG_AW-1:0]  paddr,
	input  wire [CFG_DW-1:0]  pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	sds_cfg_t cfg;

	// Configuration registers.
	sds_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Frame sequencer and datapath.
	sds_core #(
		.DELAY_DEPTH     (DELAY_DEPTH),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.TANH_TABLE_BITS (TANH_TABLE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.din    (din),
		.dout   (dout)
	);

endmodule

`default_nettype wire

>>> hw/rtl/sds_checker.sv
// Port-level checker of the stereo doubler saturator and its bind.
`timescale 1ns / 1ps
`default_nettype none

module sds_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [23:0] left_out,
	input wire [23:0] right_out
);

	// A stalled word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// A stalled word keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_out) && $stable(right_out))
		else $error("output word changed while stalled");

	// After taking a word the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a word");

	// No result appears the cycle after a word is taken.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind stereo_doubler_saturator_unit sds_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.left_out  (dout.left_out),
	.right_out (dout.right_out)
);

`default_nettype wire

>>> tb/stereo_doubler_saturator_unit_tb.sv
// Self-checking testbench for the stereo doubler saturator unit.
`timescale 1ns / 1ps

module stereo_doubler_saturator_unit_tb;
	import sds_pkg::*;

	localparam int LINE_DEPTH = 2048;
	localparam int TANH_SIZE = 1024;
	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam longint unsigned EXP_NEG1_Q30 = 64'd395007542;
	localparam logic [31:0] ASIN_QUARTER = 32'd172723447;
	localparam logic [31:0] ASIN_THREE_QUARTER = 32'd579705780;
	localparam longint DECAY_Q16 = 65208;
	localparam longint BOOST_HIGH = 8602;
	localparam longint BOOST_LOW = 4710;
	localparam longint DRIVE_BASE = 5530;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [23:0] left;
		logic [23:0] right;
	} frame_t;

	// One directed row: an optional register write before the word, then the word,
	// and an expected result where it is obvious.
	typedef struct {
		bit          do_write;
		sds_reg_t    reg_sel;
		logic [31:0] reg_val;
		logic [23:0] left;
		logic [23:0] right;
		bit          typed;
		logic [23:0] exp_left;
		logic [23:0] exp_right;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	sds_in_if din ();
	sds_out_if dout ();

	stereo_doubler_saturator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din),
		.dout(dout),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow state of the doubler.
	longint tanh_rom[TANH_SIZE + 1];
	logic [23:0] delay_line[2][LINE_DEPTH];
	longint unsigned peak_env[2];
	int write_pos;
	logic [31:0] lfo_phase;
	logic [31:0] shadow_mix;
	logic [31:0] shadow_vol;
	logic [31:0] shadow_base;
	logic [31:0] shadow_step;

	frame_t expected_frames[$];
	int errors;
	int mismatches;
	int words_sent;
	int words_checked;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_requests;
	int holds_done;
	int hold_left;
	bit typed_now;
	logic [23:0] typed_left;
	logic [23:0] typed_right;

	// Builds the tanh table with a Q.30 exponential series.
	function automatic void build_tanh_rom();
		longint unsigned zq, k, f, term, e, sum;
		for (int i = 0; i <= TANH_SIZE; i++) begin
			zq = longint'(i) << 24;
			k = zq >> 30;
			f = zq & (Q30 - 1);
			term = Q30;
			sum = Q30;
			for (int n = 1; n <= 24; n++) begin
				term = ((term * f) >> 30) / longint'(n);
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			e = sum;
			for (longint unsigned j = 0; j < k; j++) begin
				e = (e * EXP_NEG1_Q30 + (Q30 >> 1)) >> 30;
			end
			tanh_rom[i] = longint'((((Q30 - e) << 23) + ((Q30 + e) >> 1)) / (Q30 + e));
		end
	endfunction

	// Computes one output frame and advances the shadow state.
	function automatic frame_t compute_stereo_frame(logic signed [23:0] left_s,
			logic signed [23:0] right_s);
		frame_t res;
		longint x[2], acc[2];
		longint mix, vol, boost, d, arg, wet, t0, t1, frac, y, r_idx;
		longint unsigned mag, prev, dec, aabs, idx;
		logic [31:0] p, a;
		int m, mg, rd;
		x[0] = left_s;
		x[1] = right_s;
		mix = (shadow_mix > 4096) ? 4096 : longint'(shadow_mix);
		vol = (shadow_vol > 8192) ? 8192 : longint'(shadow_vol);
		acc[0] = x[0] * (4096 - mix);
		acc[1] = x[1] * (4096 - mix);
		if (mix != 0) begin
			// The LFO offset comes from the top bits of the phase, folded to a quadrant.
			p = lfo_phase & 32'hFFC0_0000;
			a = p & 32'h7FFF_FFFF;
			if (a > 32'h4000_0000) begin
				a = 32'h8000_0000 - a;
			end
			mg = (a >= ASIN_THREE_QUARTER) ? 2 : (a >= ASIN_QUARTER) ? 1 : 0;
			m = p[31] ? -mg : mg;
			for (int ch = 0; ch < 2; ch++) begin
				mag = (x[ch] < 0) ? longint'(-x[ch]) : longint'(x[ch]);
				if (mag > 8388607) begin
					mag = 8388607;
				end
				prev = peak_env[ch];
				dec = (prev * DECAY_Q16) >> 16;
				peak_env[ch] = (mag > dec) ? mag : dec;
				boost = (4 * mag > 5 * prev) ? BOOST_HIGH : BOOST_LOW;
				delay_line[ch][write_pos] = x[ch][23:0];
				r_idx = longint'(write_pos) - longint'(shadow_base) - ((ch == 0) ? m : -m);
				rd = int'((r_idx + 262144) % LINE_DEPTH);
				d = longint'($signed(delay_line[ch][rd]));
				arg = (x[ch] * boost + d * BOOST_LOW) * (DRIVE_BASE + mix);
				aabs = (arg < 0) ? longint'(-arg) : longint'(arg);
				idx = aabs >> 40;
				if (idx >= TANH_SIZE) begin
					wet = tanh_rom[TANH_SIZE];
				end else begin
					frac = longint'((aabs >> 24) & 64'hFFFF);
					t0 = tanh_rom[idx];
					t1 = tanh_rom[idx + 1];
					wet = t0 + (((t1 - t0) * frac) >>> 16);
				end
				if (arg < 0) begin
					wet = -wet;
				end
				acc[ch] = acc[ch] + wet * mix;
			end
			write_pos = (write_pos + 1) % LINE_DEPTH;
			lfo_phase = lfo_phase + shadow_step;
		end
		for (int ch = 0; ch < 2; ch++) begin
			y = (acc[ch] * vol + (longint'(1) << 23)) >>> 24;
			if (y > 8388607) begin
				y = 8388607;
			end else if (y < -8388608) begin
				y = -8388608;
			end
			if (ch == 0) begin
				res.left = y[23:0];
			end else begin
				res.right = y[23:0];
			end
		end
		return res;
	endfunction

	// Random sample that leans toward the extremes and small values.
	function automatic logic [23:0] random_sample();
		case ($urandom_range(9))
			0: begin
				return 24'h7FFFFF;
			end
			1: begin
				return 24'h800000;
			end
			2: begin
				return $urandom_range(1) ? 24'($urandom_range(255)) : -24'($urandom_range(255));
			end
			3: begin
				return 24'h0;
			end
			default: begin
				return 24'($urandom);
			end
		endcase
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit.
	initial begin
		#5ms;
		$display("stereo_doubler_saturator_unit test failed");
		$finish;
	end

	// Receiver: random stalls, with long hold-offs on request.
	always @(negedge clk) begin
		if (holds_done != hold_requests) begin
			holds_done <= hold_requests;
			hold_left <= 300;
			dout.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			dout.ready <= 1'b0;
		end else begin
			dout.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Predict each accepted input word and check each accepted output word.
	always @(posedge clk) begin
		frame_t got, want, pred;
		if (arst_n && din.valid && din.ready) begin
			pred = compute_stereo_frame(din.left_in, din.right_in);
			if (typed_now) begin
				pred.left = typed_left;
				pred.right = typed_right;
			end
			expected_frames.push_back(pred);
		end
		if (arst_n && dout.valid && dout.ready) begin
			got.left = dout.left_out;
			got.right = dout.right_out;
			if (expected_frames.size() == 0) begin
				errors++;
				if (mismatches < 10) begin
					$display("ERROR: unexpected output word %h %h", got.left, got.right);
				end
				mismatches++;
			end else begin
				want = expected_frames.pop_front();
				words_checked++;
				if (got.left !== want.left || got.right !== want.right) begin
					errors++;
					if (mismatches < 10) begin
						$display("ERROR: word %0d expected %h %h got %h %h", words_checked,
							want.left, want.right, got.left, got.right);
					end
					mismatches++;
				end
			end
		end
	end

	// Offers one word, honoring the sender idle rate; returns at a falling edge.
	task automatic send_word(logic [23:0] left_s, logic [23:0] right_s);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid <= 1'b1;
		din.left_in <= left_s;
		din.right_in <= right_s;
		do @(posedge clk); while (!din.ready);
		words_sent++;
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected word has arrived.
	task automatic drain();
		din.valid <= 1'b0;
		do @(negedge clk); while (expected_frames.size() != 0);
	endtask

	// Writes a register on the config port and reads it back.
	task automatic write_register(sds_reg_t sel, logic [31:0] value);
		logic [31:0] masked;
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		case (sel)
			REG_MIX: begin
				masked = value & 32'h1FFF;
				shadow_mix = masked;
			end
			REG_VOL: begin
				masked = value & 32'h3FFF;
				shadow_vol = masked;
			end
			REG_BASE: begin
				masked = value & 32'h7FF;
				shadow_base = masked;
			end
			default: begin
				masked = value;
				shadow_step = masked;
			end
		endcase
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== masked) begin
			errors++;
			if (mismatches < 10) begin
				$display("ERROR: register %s read %h expected %h", sel.name(), prdata, masked);
			end
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// One random phase with its own settings and idling.
	task automatic run_phase(logic [31:0] mix, logic [31:0] vol, logic [31:0] base,
			logic [31:0] step, int idle_pct, int stall_pct, int count, bit long_hold);
		write_register(REG_MIX, mix);
		write_register(REG_VOL, vol);
		write_register(REG_BASE, base);
		write_register(REG_LFO, step);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			if (long_hold && i == 40) begin
				hold_requests++;
			end
			if (i == count / 2) begin
				drain();
			end
			send_word(random_sample(), random_sample());
		end
	endtask

	directed_row_t directed[] = '{
		'{0, REG_MIX, 0, 24'h000000, 24'h000000, 1, 24'h000000, 24'h000000},
		'{0, REG_MIX, 0, 24'h7FFFFF, 24'h800000, 1, 24'h7FFFFF, 24'h800000},
		'{0, REG_MIX, 0, 24'hFFFFFF, 24'h000001, 1, 24'hFFFFFF, 24'h000001},
		'{1, REG_VOL, 0, 24'h123456, 24'hABCDEF, 1, 24'h000000, 24'h000000},
		'{1, REG_VOL, 16383, 24'h7FFFFF, 24'h800000, 1, 24'h7FFFFF, 24'h800000},
		'{0, REG_VOL, 0, 24'h0003E8, 24'hFFFC18, 1, 24'h0007D0, 24'hFFF830},
		'{1, REG_VOL, 4096, 24'h555555, 24'hAAAAAA, 1, 24'h555555, 24'hAAAAAA},
		'{1, REG_MIX, 4096, 24'h7FFFFF, 24'h800000, 0, 24'h0, 24'h0},
		'{0, REG_MIX, 0, 24'h800000, 24'h7FFFFF, 0, 24'h0, 24'h0},
		'{0, REG_MIX, 0, 24'h000000, 24'h000000, 0, 24'h0, 24'h0},
		'{0, REG_MIX, 0, 24'h000010, 24'hFFFFF0, 0, 24'h0, 24'h0},
		'{0, REG_MIX, 0, 24'h400000, 24'hC00000, 0, 24'h0, 24'h0},
		'{1, REG_MIX, 8191, 24'h200000, 24'hE00000, 0, 24'h0, 24'h0},
		'{1, REG_BASE, 0, 24'h0ABCDE, 24'hF54321, 0, 24'h0, 24'h0},
		'{0, REG_MIX, 0, 24'hFFFFFF, 24'h000001, 0, 24'h0, 24'h0},
		'{1, REG_BASE, 2047, 24'h7FFFFF, 24'h7FFFFF, 0, 24'h0, 24'h0},
		'{1, REG_LFO, 32'hFFFFFFFF, 24'h800000, 24'h800000, 0, 24'h0, 24'h0},
		'{0, REG_MIX, 0, 24'h3FFFFF, 24'hC00001, 0, 24'h0, 24'h0},
		'{1, REG_LFO, 32'h40000000, 24'h100000, 24'hF00000, 0, 24'h0, 24'h0},
		'{0, REG_MIX, 0, 24'h1FFFFF, 24'hE00001, 0, 24'h0, 24'h0},
		'{1, REG_BASE, 1, 24'h765432, 24'h89ABCD, 0, 24'h0, 24'h0},
		'{1, REG_VOL, 8192, 24'h7FFFFF, 24'h800000, 0, 24'h0, 24'h0},
		'{1, REG_MIX, 1, 24'h654321, 24'h9ABCDF, 0, 24'h0, 24'h0}
	};

	// Stimulus and end of test.
	initial begin
		int waited;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		din.valid = 1'b0;
		din.left_in = '0;
		din.right_in = '0;
		dout.ready = 1'b0;
		errors = 0;
		mismatches = 0;
		words_sent = 0;
		words_checked = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests = 0;
		holds_done = 0;
		hold_left = 0;
		typed_now = 1'b0;
		typed_left = '0;
		typed_right = '0;
		build_tanh_rom();
		for (int ch = 0; ch < 2; ch++) begin
			peak_env[ch] = 0;
			for (int i = 0; i < LINE_DEPTH; i++) begin
				delay_line[ch][i] = '0;
			end
		end
		write_pos = 0;
		lfo_phase = '0;
		shadow_mix = MIX_RST;
		shadow_vol = VOL_RST;
		shadow_base = BASE_RST;
		shadow_step = LFO_RST;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows: extremes, gain limits, mix limits and delay wrap.
		foreach (directed[i]) begin
			if (directed[i].do_write) begin
				write_register(directed[i].reg_sel, directed[i].reg_val);
			end
			typed_now = directed[i].typed;
			typed_left = directed[i].exp_left;
			typed_right = directed[i].exp_right;
			send_word(directed[i].left, directed[i].right);
		end
		drain();
		typed_now = 1'b0;

		// Random phases over several settings and idling patterns.
		run_phase(4096, 4096, 576, 71583, 0, 0, 300, 1);
		run_phase(2048, 8192, 0, 32'hFFFFFFFF, 52, 0, 300, 0);
		run_phase(8191, 16383, 2047, $urandom, 0, 52, 300, 0);
		run_phase(1 + $urandom_range(4095), $urandom_range(8192), $urandom_range(2047),
			32'h10000000 + $urandom_range(32'h0FFFFFFF), 24, 24, 300, 0);
		run_phase(0, 5000, 100, 0, 24, 24, 100, 0);
		din.valid <= 1'b0;

		waited = 0;
		while (expected_frames.size() != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_frames.size() != 0) begin
			errors++;
			$display("ERROR: %0d expected words never arrived", expected_frames.size());
		end
		$display("Sent %0d stereo words, checked %0d, over five register settings", words_sent,
			words_checked);
		$display("with sender gaps, receiver stalls and a long hold-off; %0d errors", errors);
		if (errors == 0) begin
			$display("stereo_doubler_saturator_unit test passed");
		end else begin
			$display("stereo_doubler_saturator_unit test failed");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/sds_pkg.sv
hw/rtl/sds_if.sv
hw/rtl/sds_ram.sv
hw/rtl/sds_regs.sv
hw/rtl/sds_core.sv
hw/rtl/stereo_doubler_saturator_unit.sv
hw/rtl/sds_checker.sv
tb/stereo_doubler_saturator_unit_tb.sv
